[rtl/assert_macros.svh]
// Assertion macros shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define ADSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("adsc assertion failed");

// Checked on every rising clock edge, reset included.
`define ADSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("adsc assertion failed");

`endif

[rtl/adsc_pkg.sv]
`timescale 1ns / 1ps
package adsc_pkg;

    localparam int NAME_CHARS = 31;
    localparam int NAME_STORE = 31;
    localparam int NAME_CAP   = (NAME_CHARS < 31) ? NAME_CHARS : 31;
    localparam int NAME_IDX_W = $clog2(NAME_STORE);

    localparam int NUM_BANKS = 4;
    localparam int BANK_W    = $clog2(NUM_BANKS);
    localparam int Q_DEPTH   = 2;
    localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] TARGET_RESET = 16'h180D;

    localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
    localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;
    localparam logic [7:0] AD_U16_PARTIAL   = 8'h02;
    localparam logic [7:0] AD_U16_COMPLETE  = 8'h03;
    localparam logic [7:0] AD_U128_PARTIAL  = 8'h06;
    localparam logic [7:0] AD_U128_COMPLETE = 8'h07;

    localparam logic [3:0] U128_TGT_LO = 4'd12;
    localparam logic [3:0] U128_TGT_HI = 4'd13;
    localparam logic [3:0] U128_LAST   = 4'd15;

    typedef logic [BANK_W-1:0]    t_bank;
    typedef logic [NUM_BANKS-1:0] t_bank_mask;
    typedef logic [4:0]           t_len;

    localparam t_len NAME_CAP_LEN = t_len'(NAME_CAP);

    typedef struct packed {
        t_bank bank;
        t_len  len;
        logic  seen;
    } t_desc;

    typedef struct packed {
        logic                  we;
        t_bank                 bank;
        logic [NAME_IDX_W-1:0] addr;
        logic [7:0]            data;
    } t_name_wr;

    function automatic logic [7:0] adsc_base_uuid(input logic [3:0] pos);
        logic [7:0] v;
        unique case (pos)
            4'd0:    v = 8'hFB;
            4'd1:    v = 8'h34;
            4'd2:    v = 8'h9B;
            4'd3:    v = 8'h5F;
            4'd4:    v = 8'h80;
            4'd7:    v = 8'h80;
            4'd9:    v = 8'h10;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] adsc_expected128(input logic [3:0] pos,
                                                   input logic [15:0] target);
        logic [7:0] v;
        if (pos == U128_TGT_LO) begin
            v = target[7:0];
        end else if (pos == U128_TGT_HI) begin
            v = target[15:8];
        end else begin
            v = adsc_base_uuid(pos);
        end
        return v;
    endfunction

    function automatic logic adsc_is_name(input logic [7:0] t);
        return (t == AD_NAME_SHORT) || (t == AD_NAME_COMPLETE);
    endfunction

    function automatic logic adsc_is_u16(input logic [7:0] t);
        return (t == AD_U16_PARTIAL) || (t == AD_U16_COMPLETE);
    endfunction

    function automatic logic adsc_is_u128(input logic [7:0] t);
        return (t == AD_U128_PARTIAL) || (t == AD_U128_COMPLETE);
    endfunction

    function automatic t_bank_mask adsc_bank_bit(input t_bank b);
        return t_bank_mask'(1) << b;
    endfunction

endpackage

[rtl/advertising_data_scanner_core.sv]
// The final byte queues its payload's descriptor; results leave via the output register.
// Throughput: one payload byte per cycle; a payload yields name length plus one results,
// one per cycle while the output is ready; the final byte stalls only on two queued payloads.
// Reset: synchronous, active low; clears parser, queue and output valid, sets the target
// UUID to 0x180D, and leaves the name store as it was.
`timescale 1ns / 1ps
module advertising_data_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_end_of_payload,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_item_kind,
    output logic [7:0]  o_name_char,
    output logic [4:0]  o_name_length,
    output logic        o_service_seen,
    output logic        o_run_end
);
    import adsc_pkg::*;

    logic       q_full;
    logic       q_head_valid;
    t_desc      q_head;
    t_bank_mask q_busy;
    logic       push;
    t_desc      push_desc;
    logic       pop;
    t_name_wr   name_wr;
    logic       accept;

    assign o_in_ready = !q_full || !i_end_of_payload;
    assign accept     = i_in_valid && o_in_ready;

    adsc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_accept         (accept),
        .i_payload_byte   (i_payload_byte),
        .i_end_of_payload (i_end_of_payload),
        .i_q_busy         (q_busy),
        .o_push           (push),
        .o_push_desc      (push_desc),
        .o_name_wr        (name_wr)
    );

    adsc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_desc  (push_desc),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head),
        .o_busy       (q_busy)
    );

    adsc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_name_wr      (name_wr),
        .i_head_valid   (q_head_valid),
        .i_head         (q_head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_item_kind    (o_item_kind),
        .o_name_char    (o_name_char),
        .o_name_length  (o_name_length),
        .o_service_seen (o_service_seen),
        .o_run_end      (o_run_end)
    );

endmodule

[rtl/adsc_queue.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module adsc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  adsc_pkg::t_desc     i_push_desc,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_head_valid,
    output adsc_pkg::t_desc     o_head,
    output adsc_pkg::t_bank_mask o_busy
);
    import adsc_pkg::*;

    t_desc             r_slot [Q_DEPTH];
    logic              r_wp;
    logic              r_rp;
    logic [QCNT_W-1:0] r_count;

    assign o_full       = (r_count == QCNT_W'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rp];

    always_comb begin
        o_busy = '0;
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (o_full || (o_head_valid && (r_rp == 1'(i)))) begin
                o_busy = o_busy | adsc_bank_bit(r_slot[i].bank);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_push_desc;
        end
    end

    `ADSC_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full)
    `ADSC_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_head_valid)
    `ADSC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (r_count == '0))

endmodule

[rtl/adsc_front.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module adsc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_accept,
    input  logic [7:0]           i_payload_byte,
    input  logic                 i_end_of_payload,
    input  adsc_pkg::t_bank_mask i_q_busy,
    output logic                 o_push,
    output adsc_pkg::t_desc      o_push_desc,
    output adsc_pkg::t_name_wr   o_name_wr
);
    import adsc_pkg::*;

    typedef enum logic [1:0] {PH_LEN, PH_TYPE, PH_DATA, PH_STOP} t_phase;

    logic [15:0] r_target;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_etype, n_etype;
    t_len        r_slen, n_slen;
    t_len        r_klen, n_klen;
    logic        r_seen, n_seen;
    logic        r_match, n_match;
    logic [7:0]  r_low, n_low;
    logic [3:0]  r_pos, n_pos;
    logic        r_eq, n_eq;
    t_bank       r_staged, n_staged;
    t_bank       r_kept, n_kept;

    always_comb begin
        logic       commit;
        logic [7:0] exp_b;
        t_bank_mask busy;
        t_bank      free_b;

        n_phase     = r_phase;
        n_left      = r_left;
        n_etype     = r_etype;
        n_slen      = r_slen;
        n_klen      = r_klen;
        n_seen      = r_seen;
        n_match     = r_match;
        n_low       = r_low;
        n_pos       = r_pos;
        n_eq        = r_eq;
        n_staged    = r_staged;
        n_kept      = r_kept;
        commit      = 1'b0;
        exp_b       = adsc_expected128(r_pos, r_target);
        busy        = '0;
        free_b      = '0;
        o_push      = 1'b0;
        o_push_desc = '0;
        o_name_wr   = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_LEN: begin
                    if (i_payload_byte == 8'd0) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_left  = i_payload_byte;
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_etype = i_payload_byte;
                    n_slen  = '0;
                    n_match = 1'b0;
                    n_pos   = '0;
                    n_eq    = 1'b1;
                    n_low   = '0;
                    n_left  = r_left - 8'd1;
                    if (n_left == 8'd0) begin
                        commit  = 1'b1;
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (adsc_is_name(r_etype)) begin
                        if (r_slen < NAME_CAP_LEN) begin
                            o_name_wr.we   = 1'b1;
                            o_name_wr.bank = r_staged;
                            o_name_wr.addr = r_slen[NAME_IDX_W-1:0];
                            o_name_wr.data = i_payload_byte;
                            n_slen         = r_slen + 5'd1;
                        end
                    end else if (adsc_is_u16(r_etype)) begin
                        if (!r_pos[0]) begin
                            n_low = i_payload_byte;
                        end else if ({i_payload_byte, r_low} == r_target) begin
                            n_match = 1'b1;
                        end
                        n_pos = {3'b000, ~r_pos[0]};
                    end else if (adsc_is_u128(r_etype)) begin
                        if (i_payload_byte != exp_b) begin
                            n_eq = 1'b0;
                        end
                        if (r_pos == U128_LAST) begin
                            if (r_eq && (i_payload_byte == exp_b)) begin
                                n_match = 1'b1;
                            end
                            n_eq  = 1'b1;
                            n_pos = '0;
                        end else begin
                            n_pos = r_pos + 4'd1;
                        end
                    end
                    n_left = r_left - 8'd1;
                    if (n_left == 8'd0) begin
                        commit  = 1'b1;
                        n_phase = PH_LEN;
                    end
                end
                PH_STOP: begin
                end
            endcase

            if (commit) begin
                if (adsc_is_name(n_etype)) begin
                    n_klen   = n_slen;
                    n_kept   = r_staged;
                    n_staged = r_kept;
                end else if ((adsc_is_u16(n_etype) || adsc_is_u128(n_etype)) && n_match) begin
                    n_seen = 1'b1;
                end
            end

            if (i_end_of_payload) begin
                o_push           = 1'b1;
                o_push_desc.bank = n_kept;
                o_push_desc.len  = n_klen;
                o_push_desc.seen = n_seen;
                busy = i_q_busy | adsc_bank_bit(n_staged) | adsc_bank_bit(n_kept);
                for (int i = NUM_BANKS - 1; i >= 0; i--) begin
                    if (!busy[i]) begin
                        free_b = t_bank'(i);
                    end
                end
                n_kept  = free_b;
                n_klen  = '0;
                n_slen  = '0;
                n_seen  = 1'b0;
                n_match = 1'b0;
                n_phase = PH_LEN;
                n_left  = '0;
                n_etype = '0;
                n_low   = '0;
                n_pos   = '0;
                n_eq    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
            r_phase  <= PH_LEN;
            r_left   <= '0;
            r_etype  <= '0;
            r_slen   <= '0;
            r_klen   <= '0;
            r_seen   <= 1'b0;
            r_match  <= 1'b0;
            r_low    <= '0;
            r_pos    <= '0;
            r_eq     <= 1'b1;
            r_staged <= t_bank'(0);
            r_kept   <= t_bank'(1);
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_etype  <= n_etype;
            r_slen   <= n_slen;
            r_klen   <= n_klen;
            r_seen   <= n_seen;
            r_match  <= n_match;
            r_low    <= n_low;
            r_pos    <= n_pos;
            r_eq     <= n_eq;
            r_staged <= n_staged;
            r_kept   <= n_kept;
        end
    end

    `ADSC_ASSERT(a_banks_distinct, i_clk, i_rst_n, r_staged != r_kept)
    `ADSC_ASSERT(a_staged_not_queued, i_clk, i_rst_n, (i_q_busy & adsc_bank_bit(r_staged)) == '0)
    `ADSC_ASSERT(a_data_has_bytes, i_clk, i_rst_n, (r_phase == PH_DATA) |-> (r_left != 8'd0))

endmodule

[rtl/adsc_back.sv]
`timescale 1ns / 1ps
module adsc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  adsc_pkg::t_name_wr i_name_wr,
    input  logic               i_head_valid,
    input  adsc_pkg::t_desc    i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_item_kind,
    output logic [7:0]         o_name_char,
    output logic [4:0]         o_name_length,
    output logic               o_service_seen,
    output logic               o_run_end
);
    import adsc_pkg::*;

    logic [7:0] r_name [NUM_BANKS][NAME_STORE];
    t_len       r_idx;
    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_char;
    t_len       r_len;
    logic       r_seen;
    logic       load;
    logic       is_char;

    assign load    = i_head_valid && (!r_valid || i_out_ready);
    assign is_char = (r_idx < i_head.len);
    assign o_pop   = load && !is_char;

    always_ff @(posedge i_clk) begin
        if (i_name_wr.we) begin
            r_name[i_name_wr.bank][i_name_wr.addr] <= i_name_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_char ? r_idx + 5'd1 : '0;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= !is_char;
            r_char <= is_char ? r_name[i_head.bank][r_idx[NAME_IDX_W-1:0]] : 8'd0;
            r_len  <= i_head.len;
            r_seen <= i_head.seen;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_item_kind    = r_kind;
    assign o_name_char    = r_char;
    assign o_name_length  = r_len;
    assign o_service_seen = r_seen;
    assign o_run_end      = r_kind;

endmodule

[test/tb_advertising_data_scanner_core.sv]
`timescale 1ns / 1ps
module tb_advertising_data_scanner_core;
    import adsc_pkg::*;

    typedef enum logic [1:0] {SCAN_LEN, SCAN_TYPE, SCAN_DATA, SCAN_STOP} t_scan_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_feed_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] chr;
        logic [4:0] len;
        logic       seen;
        logic       fin;
    } t_scan_report;

    // Base UUID 0000xxxx-0000-1000-8000-00805F9B34FB, byte 0 is sent first.
    localparam logic [127:0] BASE_UUID_LE = 128'h00000000_00001000_80000080_5F9B34FB;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = 16'h0000;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_payload_byte = 8'h00;
    logic        i_end_of_payload = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_item_kind;
    logic [7:0]  o_name_char;
    logic [4:0]  o_name_length;
    logic        o_service_seen;
    logic        o_run_end;

    advertising_data_scanner_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_payload_byte   (i_payload_byte),
        .i_end_of_payload (i_end_of_payload),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_item_kind      (o_item_kind),
        .o_name_char      (o_name_char),
        .o_name_length    (o_name_length),
        .o_service_seen   (o_service_seen),
        .o_run_end        (o_run_end)
    );

    always #5 i_clk = ~i_clk;

    // Scanner state as predicted from the accepted bytes.
    logic [15:0]  tgt_uuid;
    logic [7:0]   kept_name [NAME_STORE];
    logic [4:0]   kept_len;
    logic [7:0]   staged_name [NAME_STORE];
    logic [4:0]   staged_len;
    logic         seen;
    logic         el_match;
    t_scan_phase  phase;
    logic [7:0]   left;
    logic [7:0]   etype;
    logic [7:0]   uuid_lo;
    logic [3:0]   cpos;
    logic         ceq;

    t_scan_report report_due [$];
    t_feed_item   byte_feed [$];
    logic [7:0]   frame [$];
    logic [15:0]  targets [6];

    t_feed_item   next_byte;
    bit           in_fire;
    bit           out_fire;
    bit           calm;
    int           feed_gap;
    int           drain_stall;
    int           fed;
    int           taken;
    int           errors;

    function automatic logic [7:0] svc_uuid_byte(input logic [3:0] pos);
        if (pos == 4'd12) begin
            return tgt_uuid[7:0];
        end
        if (pos == 4'd13) begin
            return tgt_uuid[15:8];
        end
        return BASE_UUID_LE[pos*8 +: 8];
    endfunction

    function automatic int draw_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic frame_add(input logic [7:0] b);
        frame = {frame, b};
    endtask

    task automatic clear_scan();
        kept_len = '0;
        staged_len = '0;
        seen = 1'b0;
        el_match = 1'b0;
        phase = SCAN_LEN;
        left = '0;
        etype = '0;
        uuid_lo = '0;
        cpos = '0;
        ceq = 1'b1;
    endtask

    task automatic close_element();
        if (etype inside {AD_NAME_SHORT, AD_NAME_COMPLETE}) begin
            for (int k = 0; k < staged_len; k++) begin
                kept_name[k] = staged_name[k];
            end
            kept_len = staged_len;
        end else if ((etype inside {AD_U16_PARTIAL, AD_U16_COMPLETE,
                                    AD_U128_PARTIAL, AD_U128_COMPLETE}) && el_match) begin
            seen = 1'b1;
        end
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic last);
        t_scan_report r;
        case (phase)
            SCAN_LEN: begin
                if (b == 8'h00) begin
                    phase = SCAN_STOP;
                end else begin
                    left = b;
                    phase = SCAN_TYPE;
                end
            end
            SCAN_TYPE: begin
                etype = b;
                staged_len = '0;
                el_match = 1'b0;
                cpos = '0;
                ceq = 1'b1;
                uuid_lo = '0;
                left = left - 8'd1;
                if (left == 8'd0) begin
                    close_element();
                    phase = SCAN_LEN;
                end else begin
                    phase = SCAN_DATA;
                end
            end
            SCAN_DATA: begin
                if (etype inside {AD_NAME_SHORT, AD_NAME_COMPLETE}) begin
                    if (staged_len < NAME_CAP) begin
                        staged_name[staged_len] = b;
                        staged_len = staged_len + 5'd1;
                    end
                end else if (etype inside {AD_U16_PARTIAL, AD_U16_COMPLETE}) begin
                    if (!cpos[0]) begin
                        uuid_lo = b;
                    end else if ({b, uuid_lo} == tgt_uuid) begin
                        el_match = 1'b1;
                    end
                    cpos = {3'b000, ~cpos[0]};
                end else if (etype inside {AD_U128_PARTIAL, AD_U128_COMPLETE}) begin
                    if (b != svc_uuid_byte(cpos)) begin
                        ceq = 1'b0;
                    end
                    if (cpos == 4'd15) begin
                        if (ceq) begin
                            el_match = 1'b1;
                        end
                        ceq = 1'b1;
                        cpos = '0;
                    end else begin
                        cpos = cpos + 4'd1;
                    end
                end
                left = left - 8'd1;
                if (left == 8'd0) begin
                    close_element();
                    phase = SCAN_LEN;
                end
            end
            default: begin
            end
        endcase
        if (last) begin
            for (int k = 0; k < kept_len; k++) begin
                r = '{kind: 1'b0, chr: kept_name[k], len: kept_len, seen: seen, fin: 1'b0};
                report_due = {report_due, r};
            end
            r = '{kind: 1'b1, chr: 8'h00, len: kept_len, seen: seen, fin: 1'b1};
            report_due = {report_due, r};
            clear_scan();
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_scan_report want;
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && i_cfg_we) begin
            tgt_uuid = i_cfg_wdata;
        end
        if (in_fire) begin
            taken++;
            scan_byte(i_payload_byte, i_end_of_payload);
        end
        if (out_fire) begin
            if (report_due.size() == 0) begin
                $display("%0t ns: unexpected transfer, expected none, actual kind %0h char %0h",
                         $time, o_item_kind, o_name_char);
                errors++;
            end else begin
                want = report_due.pop_front();
                check_field("item_kind", want.kind, o_item_kind);
                check_field("name_char", want.chr, o_name_char);
                check_field("name_length", want.len, o_name_length);
                check_field("service_seen", want.seen, o_service_seen);
                check_field("run_end", want.fin, o_run_end);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (feed_gap > 0) begin
                feed_gap--;
                i_in_valid <= 1'b0;
            end else if (byte_feed.size() > 0) begin
                next_byte = byte_feed.pop_front();
                i_in_valid <= 1'b1;
                i_payload_byte <= next_byte.data;
                i_end_of_payload <= next_byte.last;
                feed_gap = draw_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_fire) begin
            drain_stall = draw_gap();
        end
        if (drain_stall > 0) begin
            drain_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic push_frame();
        t_feed_item it;
        foreach (frame[i]) begin
            it.data = frame[i];
            it.last = (i == frame.size() - 1);
            byte_feed = {byte_feed, it};
        end
        fed += frame.size();
        frame.delete();
    endtask

    task automatic ad_name(input int n);
        frame_add(8'(n + 1));
        frame_add($urandom_range(0, 1) ? AD_NAME_COMPLETE : AD_NAME_SHORT);
        repeat (n) begin
            frame_add(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom));
        end
    endtask

    task automatic ad_u16(input int pairs, input bit hit, input bit odd);
        int hit_at;
        logic [15:0] v;
        hit_at = (hit && pairs > 0) ? $urandom_range(0, pairs - 1) : -1;
        frame_add(8'(1 + 2 * pairs + odd));
        frame_add($urandom_range(0, 1) ? AD_U16_COMPLETE : AD_U16_PARTIAL);
        for (int k = 0; k < pairs; k++) begin
            v = (k == hit_at) ? tgt_uuid : 16'($urandom);
            frame_add(v[7:0]);
            frame_add(v[15:8]);
        end
        if (odd) begin
            frame_add($urandom_range(0, 1) ? tgt_uuid[7:0] : 8'($urandom));
        end
    endtask

    task automatic ad_u128(input int chunks, input bit hit, input int tail);
        int hit_at;
        int bad_pos;
        logic [7:0] flip;
        hit_at = (hit && chunks > 0) ? $urandom_range(0, chunks - 1) : -1;
        frame_add(8'(1 + 16 * chunks + tail));
        frame_add($urandom_range(0, 1) ? AD_U128_COMPLETE : AD_U128_PARTIAL);
        for (int k = 0; k < chunks; k++) begin
            bad_pos = $urandom_range(0, 15);
            flip = (k == hit_at) ? 8'h00 : 8'($urandom_range(1, 255));
            for (int p = 0; p < 16; p++) begin
                frame_add(svc_uuid_byte(4'(p)) ^ ((p == bad_pos) ? flip : 8'h00));
            end
        end
        for (int p = 0; p < tail; p++) begin
            frame_add(svc_uuid_byte(4'(p)));
        end
    endtask

    task automatic ad_other(input int n);
        logic [7:0] t;
        do begin
            t = 8'($urandom);
        end while (t inside {AD_NAME_SHORT, AD_NAME_COMPLETE, AD_U16_PARTIAL,
                             AD_U16_COMPLETE, AD_U128_PARTIAL, AD_U128_COMPLETE});
        frame_add(8'(n + 1));
        frame_add(t);
        repeat (n) begin
            frame_add(8'($urandom));
        end
    endtask

    task automatic rand_payload();
        int r;
        int cut;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 12)) begin
                frame_add(8'($urandom));
            end
        end else begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: ad_name(($urandom_range(0, 9) == 0) ? $urandom_range(28, 40)
                                                                  : $urandom_range(0, 10));
                    3, 4: ad_u16($urandom_range(0, 3), $urandom_range(0, 1),
                                 $urandom_range(0, 3) == 0);
                    5, 6: ad_u128(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 1,
                                  $urandom_range(0, 1),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0);
                    default: ad_other($urandom_range(0, 4));
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                frame_add(8'h00);
                repeat ($urandom_range(0, 4)) begin
                    frame_add(8'($urandom));
                end
            end else if (r < 24) begin
                cut = $urandom_range(1, (frame.size() > 6) ? 6 : frame.size() - 1);
                repeat (cut) begin
                    void'(frame.pop_back());
                end
            end else if (r < 30) begin
                frame_add(8'($urandom_range(1, 255)));
            end
        end
        push_frame();
    endtask

    task automatic wait_drained();
        while (taken != fed || report_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_target(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        tgt_uuid = TARGET_RESET;
        clear_scan();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero length first, an empty name replacing an earlier one, a 16-bit list
        // hit with an odd trailing byte, a length byte as the final byte, and a name
        // holding a zero byte followed by a cut-off name.
        frame = '{8'h00};
        push_frame();
        frame = '{8'h02, AD_NAME_SHORT, 8'h41, 8'h01, AD_NAME_COMPLETE};
        push_frame();
        frame = '{8'h04, AD_U16_COMPLETE, TARGET_RESET[7:0], TARGET_RESET[15:8], 8'hFF};
        push_frame();
        frame = '{8'h02, 8'hFF, 8'hAA, 8'h05};
        push_frame();
        frame = '{8'h03, AD_NAME_COMPLETE, 8'h00, 8'h7F, 8'h05, AD_NAME_SHORT, 8'h42};
        push_frame();
        wait_drained();

        targets = '{16'h0000, 16'hFFFF, 16'($urandom), TARGET_RESET, 16'($urandom), 16'h8001};
        foreach (targets[i]) begin
            write_target(targets[i]);
            calm = ($urandom_range(0, 3) == 0);
            while (fed < 22 + 58 * (i + 1)) begin
                rand_payload();
            end
            wait_drained();
        end

        if (errors == 0 && report_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
